/* rtl/core/scrolling_text_console_writer_assert.svh */
// Assertion macros for the scrolling text console writer.
`ifndef SCROLLING_TEXT_CONSOLE_WRITER_ASSERT_SVH
`define SCROLLING_TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define STC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrolling console check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define STC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrolling console check failed");

`else

`define STC_ASSERT_IMPLY(label, ante, cons)
`define STC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/stc_pkg.sv */
// Shared types and constants for the scrolling text console writer.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic latch;
        logic eval;
        logic write;
        logic sweep;
        logic load_out;
    } stc_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    is_newline;
        logic    row_valid;
        logic    sweep_last;
        logic    out_free;
    } stc_status_t;

endpackage

`default_nettype wire

/* rtl/core/stc_ctrl.sv */
// Controller state machine for the scrolling text console writer.
`timescale 1ns / 1ps
`default_nettype none

module stc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output stc_pkg::stc_cmd_t  cmd,
    input  stc_pkg::stc_status_t status
);
    import stc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUT,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    assign in_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.op == OP_PUT && !status.is_newline)
                    state_next = ST_PUT;
                else
                    state_next = ST_FINISH;
            end
            ST_PUT:
            begin
                if (status.row_valid)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                    state_next = ST_PUT;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/stc_datapath.sv */
// Datapath for the scrolling text console writer: caret, cell memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module stc_datapath #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stc_pkg::stc_cmd_t             cmd,
    output stc_pkg::stc_status_t          status,
    input  logic [1:0]                    in_opcode,
    input  logic [7:0]                    in_char,
    input  logic [5:0]                    in_row,
    input  logic [6:0]                    in_col,
    input  logic                          cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [5:0]                    caret_row_now,
    output logic [6:0]                    caret_col_now,
    output logic [7:0]                    cell_data,
    output logic                          did_scroll
);
    import stc_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CALC_W = 10;
    localparam logic [CALC_W-1:0] MAX_COLS_C = CALC_W'(MAX_COLUMNS);
    localparam logic [CALC_W-1:0] MAX_ROWS_C = CALC_W'(MAX_ROWS);
    localparam logic [COL_W-1:0]  SWEEP_LAST = COL_W'(MAX_COLUMNS - 1);

    // item registers
    opcode_t      op_reg;
    logic [7:0]   char_reg;
    logic [5:0]   rrow_reg;
    logic [6:0]   rcol_reg;

    // console state
    logic [7:0]          cols_reg;
    logic [6:0]          rows_reg;
    logic [ROW_W-1:0]    top_reg;
    logic [ROW_W-1:0]    caret_row_reg;
    logic [COL_W-1:0]    caret_col_reg;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [COL_W-1:0]    sweep_cnt_reg;
    logic                scroll_reg;
    logic                hit_reg;
    logic [7:0]          rd_data_reg;

    // result register
    logic       out_valid_reg;
    logic [5:0] out_row_reg;
    logic [6:0] out_col_reg;
    logic [7:0] out_data_reg;
    logic       out_scroll_reg;

    logic [7:0] mem [DEPTH];

    logic [CALC_W-1:0] cols_ext;
    logic [CALC_W-1:0] rows_ext;
    logic [CALC_W-1:0] eff_cols;
    logic [CALC_W-1:0] eff_rows;
    logic [CALC_W-1:0] rows_m1;
    logic [CALC_W-1:0] row_inc;
    logic [CALC_W-1:0] top_inc;
    logic [CALC_W-1:0] top_wrapped;
    logic [CALC_W-1:0] caret_sum;
    logic [CALC_W-1:0] caret_phys_full;
    logic [CALC_W-1:0] read_sum;
    logic [CALC_W-1:0] read_phys_full;
    logic [ROW_W-1:0]  caret_phys;
    logic [ROW_W-1:0]  read_phys;
    logic [ADDR_W-1:0] read_addr;
    logic              wrap;
    logic              scroll_now;
    logic              read_hit;

    always_comb
    begin
        cols_ext = CALC_W'(cols_reg);
        rows_ext = CALC_W'(rows_reg);
        if (cols_ext < CALC_W'(2))
            eff_cols = CALC_W'(2);
        else if (cols_ext > MAX_COLS_C)
            eff_cols = MAX_COLS_C;
        else
            eff_cols = cols_ext;
        if (rows_ext < CALC_W'(1))
            eff_rows = CALC_W'(1);
        else if (rows_ext > MAX_ROWS_C)
            eff_rows = MAX_ROWS_C;
        else
            eff_rows = rows_ext;
        rows_m1 = eff_rows - CALC_W'(1);

        wrap = (char_reg == NEWLINE_CODE)
            || (CALC_W'(caret_col_reg) >= eff_cols - CALC_W'(1));
        row_inc    = CALC_W'(caret_row_reg) + CALC_W'(1);
        scroll_now = wrap && (row_inc >= eff_rows);
        top_inc    = CALC_W'(top_reg) + CALC_W'(1);
        top_wrapped = (top_inc >= eff_rows) ? '0 : top_inc;

        caret_sum       = CALC_W'(top_reg) + CALC_W'(caret_row_reg);
        caret_phys_full = (caret_sum >= eff_rows) ? caret_sum - eff_rows : caret_sum;
        caret_phys      = caret_phys_full[ROW_W-1:0];

        read_sum       = CALC_W'(top_reg) + CALC_W'(rrow_reg);
        read_phys_full = (read_sum >= eff_rows) ? read_sum - eff_rows : read_sum;
        read_phys      = read_phys_full[ROW_W-1:0];
        read_addr      = {read_phys, COL_W'(rcol_reg)};
        read_hit = (op_reg == OP_READ)
            && (CALC_W'(rrow_reg) < eff_rows)
            && (CALC_W'(rcol_reg) < eff_cols)
            && row_valid_reg[read_phys];
    end

    always_comb
    begin
        status.op         = op_reg;
        status.is_newline = (char_reg == NEWLINE_CODE);
        status.row_valid  = row_valid_reg[caret_phys];
        status.sweep_last = (sweep_cnt_reg == SWEEP_LAST);
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= 8'd128;
            rows_reg      <= 7'd64;
            top_reg       <= '0;
            caret_row_reg <= '0;
            caret_col_reg <= '0;
            row_valid_reg <= '0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS))
            begin
                if (cfg_index == CFG_COLUMNS)
                    cols_reg <= cfg_data;
                else
                    rows_reg <= cfg_data[6:0];
                top_reg       <= '0;
                caret_row_reg <= '0;
                caret_col_reg <= '0;
                row_valid_reg <= '0;
            end

            if (cmd.eval)
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (wrap)
                        begin
                            caret_col_reg <= '0;
                            if (scroll_now)
                            begin
                                caret_row_reg          <= rows_m1[ROW_W-1:0];
                                top_reg                <= top_wrapped[ROW_W-1:0];
                                row_valid_reg[top_reg] <= 1'b0;
                            end
                            else
                                caret_row_reg <= row_inc[ROW_W-1:0];
                        end
                    end
                    OP_CLEAR:
                    begin
                        top_reg       <= '0;
                        caret_row_reg <= '0;
                        caret_col_reg <= '0;
                        row_valid_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // zero a fresh row one cell per cycle, then mark it valid
            if (cmd.sweep)
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_cnt_reg             <= '0;
                    row_valid_reg[caret_phys] <= 1'b1;
                end
                else
                    sweep_cnt_reg <= sweep_cnt_reg + COL_W'(1);
            end

            if (cmd.write)
                caret_col_reg <= caret_col_reg + COL_W'(1);

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode_t'(in_opcode);
            char_reg <= in_char;
            rrow_reg <= in_row;
            rcol_reg <= in_col;
        end
        if (cmd.eval)
        begin
            scroll_reg  <= (op_reg == OP_PUT) && scroll_now;
            hit_reg     <= read_hit;
            rd_data_reg <= mem[read_addr];
        end
        if (cmd.sweep)
            mem[{caret_phys, sweep_cnt_reg}] <= 8'd0;
        else if (cmd.write)
            mem[{caret_phys, caret_col_reg}] <= char_reg;
        if (cmd.load_out)
        begin
            out_row_reg    <= 6'(caret_row_reg);
            out_col_reg    <= 7'(caret_col_reg);
            out_data_reg   <= hit_reg ? rd_data_reg : 8'd0;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign caret_row_now = out_row_reg;
    assign caret_col_now = out_col_reg;
    assign cell_data     = out_data_reg;
    assign did_scroll    = out_scroll_reg;

endmodule

`default_nettype wire

/* rtl/core/scrolling_text_console_writer.sv */
// Top level of the scrolling text console writer: stream ports, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   s_axis carries one operation per item: tuser holds the opcode (put, clear,
//   read, no-op), tdata the character and the read row and column.
//   m_axis returns one result per item: caret position after the operation,
//   the cell read (zero otherwise) and a flag for a put that scrolled.
//   cfg writes columns_in_use (index 0) or rows_in_use (index 1); either write
//   also clears the console. Write it only while the block is idle.
// Operation flow:
//   One item is in flight at a time. A read, clear, no-op or newline passes
//   through evaluate and finish before the next accept; an ordinary put also writes its cell.
//   A put into a row not yet cleared since the last clear or scroll first
//   zeroes that row in the cell memory, one cell per cycle, before the write.
//   The cell memory has a single write port, shared by zeroing and writing.
// Reset: asynchronous, rst_n low. Per-row valid bits clear at once, so the
//   console reads empty right after reset with no clearing pass.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the next item is still accepted and finishes once the register frees.

`include "scrolling_text_console_writer_assert.svh"

module scrolling_text_console_writer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // char_code[7:0], read_row[13:8], read_col[20:14], zero fill
    input  logic [23:0]                   s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // caret_row_now[5:0], caret_col_now[12:6], cell_data[20:13], did_scroll[21], zero fill
    output logic [23:0]                   m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import stc_pkg::*;

    stc_cmd_t    cmd;
    stc_status_t status;
    logic [5:0]  caret_row_now;
    logic [6:0]  caret_col_now;
    logic [7:0]  cell_data;
    logic        did_scroll;

    assign cfg_ready = 1'b1;

    stc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_opcode     (s_axis_tuser),
        .in_char       (s_axis_tdata[7:0]),
        .in_row        (s_axis_tdata[13:8]),
        .in_col        (s_axis_tdata[20:14]),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .caret_row_now (caret_row_now),
        .caret_col_now (caret_col_now),
        .cell_data     (cell_data),
        .did_scroll    (did_scroll)
    );

    assign m_axis_tdata = {2'b00, did_scroll, cell_data, caret_col_now, caret_row_now};

    `STC_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `STC_ASSERT_NEXT(a_sweep_marks_row, cmd.sweep && status.sweep_last, status.row_valid)
    `STC_ASSERT_IMPLY(a_no_result_overwrite, cmd.load_out, !m_axis_tvalid || m_axis_tready)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the scrolling text console writer: directed table, random phases.
`timescale 1ns / 1ps

module tb_top;
    import stc_pkg::*;

    localparam int MAX_COLS    = 128;
    localparam int MAX_LINES   = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int STALL_LIMIT = 4000;
    localparam int REG_SETTLE  = 4;
    localparam int TAIL_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic [1:0] fill;
        logic       scrolled;
        logic [7:0] cell_code;
        logic [6:0] col;
        logic [5:0] row;
    } console_result_t;

    typedef enum logic {STEP_OP, STEP_REG} step_kind_t;

    // value: character for a put, register value for a register write
    typedef struct {
        step_kind_t           kind;
        opcode_t              op;
        logic [7:0]           value;
        logic [5:0]           rrow;
        logic [6:0]           rcol;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 typed;
        logic [5:0]           e_row;
        logic [6:0]           e_col;
        logic [7:0]           e_cell;
        logic                 e_scroll;
    } directed_step_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = OP_NOP;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_COLUMNS;
    logic [7:0]           cfg_data      = '0;

    scrolling_text_console_writer #(
        .MAX_COLUMNS(MAX_COLS),
        .MAX_ROWS   (MAX_LINES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // console model state
    logic [7:0] cells [0:MAX_LINES-1][0:MAX_COLS-1];
    int         top_row   = 0;
    int         caret_row = 0;
    int         caret_col = 0;
    logic [7:0] cols_reg  = 8'd128;
    logic [6:0] rows_reg  = 7'd64;

    console_result_t pending_results [$];
    int              mismatches   = 0;
    int              quiet_cycles = 0;
    bit              no_gaps      = 1'b0;

    directed_step_t directed_steps [0:34] = '{
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd63, 7'd127, CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_NOP,   8'hFF, 6'd63, 7'd127, CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h41, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd2, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'hFF, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd3, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd3, 8'h41, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd2,   CFG_COLUMNS, 1'b1, 6'd0, 7'd3, 8'hFF, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h0A, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd1, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd3,   CFG_COLUMNS, 1'b1, 6'd1, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_CLEAR, 8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h80, 6'd0,  7'd0,   CFG_ROWS,    1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h78, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h79, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h00, 1'b1},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h79, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd1,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd1,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'hFF, 6'd0,  7'd0,   CFG_UNMAPPED_LO, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h55, 6'd0,  7'd0,   CFG_UNMAPPED_HI, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd1, 8'h79, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h0A, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b1},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'hFF, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h7F, 6'd0,  7'd0,   CFG_ROWS,    1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd63, 7'd127, CFG_COLUMNS, 1'b1, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h03, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_REG, OP_NOP,   8'h02, 6'd0,  7'd0,   CFG_ROWS,    1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h61, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h62, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h63, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_PUT,   8'h0A, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd0,  7'd0,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0},
        '{STEP_OP,  OP_READ,  8'h00, 6'd1,  7'd1,   CFG_COLUMNS, 1'b0, 6'd0, 7'd0, 8'h00, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int width_now();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int height_now();
        if (rows_reg < 1) return 1;
        if (rows_reg > MAX_LINES) return MAX_LINES;
        return rows_reg;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic wipe_console();
        foreach (cells[r, c]) cells[r][c] = '0;
        top_row   = 0;
        caret_row = 0;
        caret_col = 0;
    endtask

    task automatic advance_console(input opcode_t op, input logic [7:0] ch,
                                   input logic [5:0] rr, input logic [6:0] rc,
                                   output console_result_t res);
        int w;
        int h;
        int old_top;
        w   = width_now();
        h   = height_now();
        res = '0;
        case (op)
            OP_PUT:
            begin
                if (ch == NEWLINE_CODE || caret_col >= w - 1)
                begin
                    cells[(top_row + caret_row) % h][caret_col] = '0;
                    caret_row++;
                    caret_col = 0;
                    if (caret_row >= h)
                    begin
                        old_top = top_row % h;
                        for (int c = 0; c < MAX_COLS; c++) cells[old_top][c] = '0;
                        top_row      = (old_top + 1) % h;
                        caret_row    = h - 1;
                        res.scrolled = 1'b1;
                    end
                end
                if (ch != NEWLINE_CODE)
                begin
                    cells[(top_row + caret_row) % h][caret_col] = ch;
                    caret_col++;
                end
            end
            OP_CLEAR: wipe_console();
            OP_READ:
            begin
                if (rr < h && rc < w) res.cell_code = cells[(top_row + rr) % h][rc];
            end
            default: ;
        endcase
        res.row = caret_row;
        res.col = caret_col;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_op(input opcode_t op, input logic [7:0] ch, input logic [5:0] rr,
                           input logic [6:0] rc, input logic typed,
                           input console_result_t want);
        int              gap;
        console_result_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, rc, rr, ch};
        do @(posedge clk); while (!s_axis_tready);
        advance_console(op, ch, rr, rc, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_console_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        drain();
        repeat (REG_SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_COLUMNS)
        begin
            cols_reg = val;
            wipe_console();
        end
        else if (idx == CFG_ROWS)
        begin
            rows_reg = val[6:0];
            wipe_console();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output stall pattern
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        console_result_t got;
        console_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
                flag_mismatch("result with no item pending", got, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.row != want.row) flag_mismatch("caret_row_now", got.row, want.row);
                if (got.col != want.col) flag_mismatch("caret_col_now", got.col, want.col);
                if (got.cell_code != want.cell_code)
                    flag_mismatch("cell_data", got.cell_code, want.cell_code);
                if (got.scrolled != want.scrolled)
                    flag_mismatch("did_scroll", got.scrolled, want.scrolled);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        directed_step_t  st;
        console_result_t want;
        opcode_t         op;
        logic [7:0]      ch;
        logic [5:0]      rr;
        logic [6:0]      rc;
        logic [7:0]      cols_val;
        logic [7:0]      rows_val;
        int              nl_pct;
        int              put_pct;
        int              pause_at;
        int              pick;

        wipe_console();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            st = directed_steps[i];
            if (st.kind == STEP_REG)
                write_console_reg(st.reg_idx, st.value);
            else
            begin
                want = '{2'b00, st.e_scroll, st.e_cell, st.e_col, st.e_row};
                send_op(st.op, st.value, st.rrow, st.rcol, st.typed, want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            put_pct = 60;
            case (phase)
                0:
                begin
                    cols_val = $urandom_range(2, 8);
                    rows_val = $urandom_range(1, 4);
                    nl_pct   = 15;
                end
                1:
                begin
                    cols_val = 8'd128;
                    rows_val = 8'd64;
                    nl_pct   = 80;
                end
                2:
                begin
                    cols_val = $urandom_range(0, 1);
                    rows_val = $urandom_range(1, 3);
                    nl_pct   = 10;
                end
                3:
                begin
                    cols_val = $urandom_range(129, 255);
                    rows_val = $urandom_range(65, 255);
                    nl_pct   = 0;
                    put_pct  = 90;
                end
                default:
                begin
                    cols_val = $urandom_range(2, 16);
                    rows_val = 8'($urandom_range(0, 8)) | (8'($urandom_range(0, 1)) << 7);
                    nl_pct   = $urandom_range(5, 30);
                end
            endcase
            no_gaps = (phase % 3 == 1);
            if ($urandom_range(0, 1))
            begin
                write_console_reg(CFG_COLUMNS, cols_val);
                write_console_reg(CFG_ROWS, rows_val);
            end
            else
            begin
                write_console_reg(CFG_ROWS, rows_val);
                write_console_reg(CFG_COLUMNS, cols_val);
            end
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == pause_at) drain();
                ch   = $urandom_range(0, 255);
                rr   = $urandom_range(0, 63);
                rc   = $urandom_range(0, 127);
                pick = $urandom_range(0, 99);
                if (pick < put_pct)
                begin
                    op = OP_PUT;
                    if ($urandom_range(0, 99) < nl_pct)
                        ch = NEWLINE_CODE;
                    else if ($urandom_range(0, 3) != 0)
                        ch = $urandom_range(32, 126);
                end
                else if (pick < put_pct + (100 - put_pct) * 7 / 10)
                begin
                    op = OP_READ;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        rr = $urandom_range(0, height_now() - 1);
                        rc = $urandom_range(0, width_now() - 1);
                    end
                end
                else if (pick < 96)
                    op = OP_CLEAR;
                else
                    op = OP_NOP;
                send_op(op, ch, rr, rc, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
